### src/bmr_pkg.sv
`default_nettype none

package bmr_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;

    // memory word: 64 pixels of one row
    localparam int WORD_BITS = 64;
    localparam int WORD_LG   = 6;

    localparam int COORD_W = 12;
    localparam int GRID_W  = 10;
    localparam int ALPHA_W = 8;
    // signed compare width, holds -8192..8191
    localparam int CMP_W   = 14;

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(512);

    typedef enum logic [1:0] {
        MODE_WRITE      = 2'd0,
        MODE_POINT      = 2'd1,
        MODE_RECT_TEST  = 2'd2,
        MODE_RECT_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } state_t;

    // per-word span control for the mask unit
    typedef struct packed {
        logic               first;
        logic               last;
        logic [WORD_LG-1:0] lo_bit;
        logic [WORD_LG-1:0] hi_bit;
        logic               set_bit;
    } mask_ctl_t;

endpackage

`default_nettype wire

### src/bmr_mem.sv
`default_nettype none

module bmr_mem
    import bmr_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic [WORD_BITS-1:0] wdata,
    input  wire logic                 re,
    input  wire logic [AW-1:0]        raddr,
    output logic      [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/bmr_mask_unit.sv
`default_nettype none

module bmr_mask_unit
    import bmr_pkg::*;
(
    input  wire mask_ctl_t            ctl,
    input  wire logic [WORD_BITS-1:0] rdata,
    output logic                      any_hit,
    output logic      [WORD_BITS-1:0] wdata
);

    logic [WORD_LG-1:0]   lo;
    logic [WORD_LG-1:0]   hi;
    logic [WORD_BITS-1:0] mask;

    always_comb
    begin
        lo = ctl.first ? ctl.lo_bit : '0;
        hi = ctl.last ? ctl.hi_bit : WORD_LG'(WORD_BITS - 1);
        // bits lo..hi of this word fall inside the span
        mask = ({WORD_BITS{1'b1}} << lo)
             & ({WORD_BITS{1'b1}} >> (WORD_LG'(WORD_BITS - 1) - hi));
        any_hit = |(rdata & mask);
        wdata = (rdata & ~mask) | (ctl.set_bit ? mask : '0);
    end

endmodule

`default_nettype wire

### src/bitmap_mask_region_engine.sv
// bitmap_mask_region_engine
//
// Keeps a one-bit solid mask over a pixel grid. Items arrive on the input
// channel (valid/stall); each gives exactly one hit result on the output
// channel. The user must write grid_width and grid_height through cfg_we/
// cfg_index/cfg_wdata only while the block is idle; it does not enforce this.
//
// The mask sits in a single memory of 64-pixel words, one row padded to a
// power of two of words. Every word is read once and then, for writes and
// clears, written back, so the block works on one item at a time:
//   point write / point test: one word, none off the grid
//   rectangle test / clear: every word covered, a test stops
//   at the first solid word; an empty or off-grid rectangle reads none
// Each word is read in READ, then evaluated (and written back) in EVAL.
//
// After reset the block sweeps the memory to zero, one word a cycle:
// MAX_HEIGHT * 2**max(1, ceil(log2(ceil(MAX_WIDTH/64)))) words (4096 at 512x512),
// with in_stall high. A finished result waits in the output register while
// out_stall is high; the next item is taken once the result is loaded there.
`default_nettype none

module bitmap_mask_region_engine
    import bmr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic        [GRID_W-1:0]  cfg_wdata,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic        [1:0]         mode,
    input  wire logic signed [COORD_W-1:0] left_x,
    input  wire logic signed [COORD_W-1:0] top_y,
    input  wire logic signed [COORD_W-1:0] right_x,
    input  wire logic signed [COORD_W-1:0] bottom_y,
    input  wire logic        [ALPHA_W-1:0] alpha,
    input  wire logic                      off_grid_solid,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           hit
);

    localparam int XB        = $clog2(MAX_WIDTH);
    localparam int YB        = $clog2(MAX_HEIGHT);
    localparam int ROW_WORDS = (MAX_WIDTH + WORD_BITS - 1) / WORD_BITS;
    localparam int XW_BITS   = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int XE        = XW_BITS + WORD_LG;
    localparam int AW        = YB + XW_BITS;
    localparam int DEPTH     = MAX_HEIGHT * (2 ** XW_BITS);

    state_t state_reg, state_next;

    logic [GRID_W-1:0] grid_width_reg, grid_height_reg;
    logic [AW-1:0]     clr_reg, clr_next;

    mode_t                      mode_reg;
    logic signed [COORD_W-1:0]  lx_reg, ty_reg, rx_reg, by_reg;
    logic                       solid_reg, outside_reg;

    logic [XB-1:0]      lo_x_reg, lo_x_next, hi_x_reg, hi_x_next;
    logic [YB-1:0]      lo_y_reg, lo_y_next, hi_y_reg, hi_y_next;
    logic [YB-1:0]      cur_y_reg, cur_y_next;
    logic [XW_BITS-1:0] cur_xw_reg, cur_xw_next;
    logic               res_hit_reg, res_hit_next;
    logic               out_valid_reg, out_valid_next;
    logic               hit_reg, hit_next;

    logic signed [CMP_W-1:0] w_s, h_s, lx_s, ty_s, rx_s, by_s;
    logic signed [CMP_W-1:0] a_lo, a_hi, a_top, a_bot;
    logic                    on_grid, rect_out, pt_item, span_ok, go_walk;

    logic [XE-1:0]      lo_ext, hi_ext;
    logic [XW_BITS-1:0] lo_word, hi_word;
    mask_ctl_t          ctl;
    logic               any_hit, test_item, walk_end;
    logic [WORD_BITS-1:0] mem_rdata, merged;

    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_RESET;
            grid_height_reg <= GRID_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_GRID_WIDTH)
            begin
                grid_width_reg <= cfg_wdata;
            end
            else
            begin
                grid_height_reg <= cfg_wdata;
            end
        end
    end

    // ---------------- item setup ----------------
    always_comb
    begin
        w_s = (grid_width_reg == '0) ? CMP_W'(1)
            : (CMP_W'(grid_width_reg) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH)
            : CMP_W'(grid_width_reg);
        h_s = (grid_height_reg == '0) ? CMP_W'(1)
            : (CMP_W'(grid_height_reg) > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT)
            : CMP_W'(grid_height_reg);
        lx_s = CMP_W'(lx_reg);
        ty_s = CMP_W'(ty_reg);
        rx_s = CMP_W'(rx_reg);
        by_s = CMP_W'(by_reg);

        pt_item = (mode_reg == MODE_WRITE) || (mode_reg == MODE_POINT);
        on_grid = (lx_s >= 0) && (lx_s < w_s) && (ty_s >= 0) && (ty_s < h_s);
        rect_out = (mode_reg == MODE_RECT_TEST) && outside_reg
                 && ((lx_s < 0) || (ty_s < 0) || (rx_s >= w_s) || (by_s >= h_s));

        // clamp to the grid; a point is a one-pixel span
        a_lo  = pt_item ? lx_s : ((lx_s < 0) ? CMP_W'(0) : lx_s);
        a_hi  = pt_item ? lx_s : ((rx_s > w_s - CMP_W'(1)) ? w_s - CMP_W'(1) : rx_s);
        a_top = pt_item ? ty_s : ((ty_s < 0) ? CMP_W'(0) : ty_s);
        a_bot = pt_item ? ty_s : ((by_s > h_s - CMP_W'(1)) ? h_s - CMP_W'(1) : by_s);
        span_ok = (a_lo <= a_hi) && (a_top <= a_bot);
        go_walk = pt_item ? on_grid : (!rect_out && span_ok);
    end

    // ---------------- word walk control ----------------
    always_comb
    begin
        lo_ext = XE'(lo_x_reg);
        hi_ext = XE'(hi_x_reg);
        lo_word = lo_ext[XE-1:WORD_LG];
        hi_word = hi_ext[XE-1:WORD_LG];
        ctl.first   = (cur_xw_reg == lo_word);
        ctl.last    = (cur_xw_reg == hi_word);
        ctl.lo_bit  = lo_ext[WORD_LG-1:0];
        ctl.hi_bit  = hi_ext[WORD_LG-1:0];
        ctl.set_bit = (mode_reg == MODE_WRITE) && solid_reg;
        test_item = (mode_reg == MODE_POINT) || (mode_reg == MODE_RECT_TEST);
        walk_end = (test_item && any_hit) || (ctl.last && (cur_y_reg == hi_y_reg));
    end

    bmr_mask_unit u_mask (
        .ctl     (ctl),
        .rdata   (mem_rdata),
        .any_hit (any_hit),
        .wdata   (merged)
    );

    bmr_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = go_walk ? ST_READ : ST_DONE;
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = walk_end ? ST_DONE : ST_READ;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- outputs and datapath ----------------
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        mem_we    = 1'b0;
        mem_waddr = {cur_y_reg, cur_xw_reg};
        mem_wdata = merged;
        mem_re    = 1'b0;
        mem_raddr = {cur_y_reg, cur_xw_reg};

        clr_next       = clr_reg;
        lo_x_next      = lo_x_reg;
        hi_x_next      = hi_x_reg;
        lo_y_next      = lo_y_reg;
        hi_y_next      = hi_y_reg;
        cur_y_next     = cur_y_reg;
        cur_xw_next    = cur_xw_reg;
        res_hit_next   = res_hit_reg;
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
            end
            ST_SETUP:
            begin
                lo_x_next   = XB'(a_lo);
                hi_x_next   = XB'(a_hi);
                lo_y_next   = YB'(a_top);
                hi_y_next   = YB'(a_bot);
                cur_y_next  = YB'(a_top);
                cur_xw_next = XW_BITS'(XE'(XB'(a_lo)) >> WORD_LG);
                res_hit_next = rect_out || ((mode_reg == MODE_POINT) && !on_grid
                                            && outside_reg);
            end
            ST_READ:
            begin
                mem_re = 1'b1;
            end
            ST_EVAL:
            begin
                mem_we = (mode_reg == MODE_WRITE) || (mode_reg == MODE_RECT_CLEAR);
                res_hit_next = test_item && any_hit;
                if (ctl.last)
                begin
                    cur_y_next  = cur_y_reg + YB'(1);
                    cur_xw_next = lo_word;
                end
                else
                begin
                    cur_xw_next = cur_xw_reg + XW_BITS'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = res_hit_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            mode_reg    <= mode_t'(mode);
            lx_reg      <= left_x;
            ty_reg      <= top_y;
            rx_reg      <= right_x;
            by_reg      <= bottom_y;
            solid_reg   <= (alpha != '0);
            outside_reg <= off_grid_solid;
        end
        lo_x_reg    <= lo_x_next;
        hi_x_reg    <= hi_x_next;
        lo_y_reg    <= lo_y_next;
        hi_y_reg    <= hi_y_next;
        cur_y_reg   <= cur_y_next;
        cur_xw_reg  <= cur_xw_next;
        res_hit_reg <= res_hit_next;
        hit_reg     <= hit_next;
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

    // ---------------- checks ----------------
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_DONE || state_reg == ST_SETUP)
        |-> !mem_we)
        else $error("mask memory written outside a walk or clear");

    a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EVAL |-> $past(state_reg) == ST_READ)
        else $error("word evaluated without a preceding read");

    a_row_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> (cur_y_reg >= lo_y_reg) && (cur_y_reg <= hi_y_reg))
        else $error("walk row left the clamped span");

    a_point_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL && pt_item) |-> (ctl.first && ctl.last && walk_end
                                               || mode_reg == MODE_POINT && any_hit))
        else $error("point item walked more than one word");

endmodule

`default_nettype wire
